[rtl/acs_pkg.sv]
// Package for the alpha coverage statistics core.
// Holds the queued pixel type, record and verdict codes and the sRGB decode table.
// No dependencies.
package acs_pkg;

  localparam int unsigned MaxPixelsDef  = 16777216;
  localparam int unsigned NumBucketsDef = 16;
  localparam int unsigned NumRecords    = 30;

  localparam logic [4:0] REC_TOTAL     = 5'd0;
  localparam logic [4:0] REC_ZERO      = 5'd1;
  localparam logic [4:0] REC_MID       = 5'd2;
  localparam logic [4:0] REC_OPAQUE    = 5'd3;
  localparam logic [4:0] REC_MIN       = 5'd4;
  localparam logic [4:0] REC_MAX       = 5'd5;
  localparam logic [4:0] REC_SUM       = 5'd6;
  localparam logic [4:0] REC_MODE_CODE = 5'd7;
  localparam logic [4:0] REC_MODE_CNT  = 5'd8;
  localparam logic [4:0] REC_TESTED    = 5'd9;
  localparam logic [4:0] REC_LIN_VIOL  = 5'd10;
  localparam logic [4:0] REC_RAW_VIOL  = 5'd11;
  localparam logic [4:0] REC_PREMUL    = 5'd12;
  localparam logic [4:0] REC_ALPHA     = 5'd13;
  localparam logic [4:0] REC_BUCKET0   = 5'd14;
  localparam logic [4:0] REC_LAST      = 5'd29;

  localparam logic [1:0] PREMUL_INCONCLUSIVE = 2'd0;
  localparam logic [1:0] PREMUL_NOT          = 2'd1;
  localparam logic [1:0] PREMUL_CONSISTENT   = 2'd2;

  localparam logic [1:0] ALPHA_MIXED   = 2'd0;
  localparam logic [1:0] ALPHA_OPAQUE  = 2'd1;
  localparam logic [1:0] ALPHA_ZERO    = 2'd2;
  localparam logic [1:0] ALPHA_UNIFORM = 2'd3;

  localparam logic [1:0] CFG_SRGB = 2'd0;

  typedef struct packed {
    logic [7:0] alpha;
    logic       frame_end;
    logic       raw_viol;
    logic       lin_viol;
  } item_t;

  typedef logic [15:0] lin_lut_t [256];

  function automatic lin_lut_t build_lin_lut();
    lin_lut_t    t;
    logic [63:0] n, yq, y2, lo, hi, md, p2, p4, p5, v;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        v = (64'(c) * 64'd13107200 + 64'd329460) / 64'd658920;
      end else begin
        n  = 64'(c) * 64'd1000 + 64'd14025;
        yq = (n << 30) / 64'd269025;
        if (yq > (64'd1 << 30)) yq = 64'd1 << 30;
        y2 = (yq * yq) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          md = lo + (hi - lo + 64'd1) / 64'd2;
          p2 = (md * md) >> 30;
          p4 = (p2 * p2) >> 30;
          p5 = (p4 * md) >> 30;
          if (p5 <= y2) lo = md;
          else hi = md - 64'd1;
        end
        v = (y2 * lo) >> 30;
        v = (v + (64'd1 << 13)) >> 14;
        if (v > 64'd65535) v = 64'd65535;
      end
      t[c] = v[15:0];
    end
    return t;
  endfunction

  localparam lin_lut_t LinLut = build_lin_lut();

endpackage

[rtl/acs_if.sv]
// Stream interfaces of the alpha coverage statistics core.
// Depends on nothing; pixel channel in, record channel out.
interface acs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       frame_end;
  modport source (output valid, red, green, blue, alpha, frame_end, input ready);
  modport sink   (input valid, red, green, blue, alpha, frame_end, output ready);
endinterface

interface acs_record_if;
  logic        valid;
  logic        ready;
  logic [4:0]  record_index;
  logic [31:0] record_value;
  logic        last_record;
  modport source (output valid, record_index, record_value, last_record, input ready);
  modport sink   (input valid, record_index, record_value, last_record, output ready);
endinterface

[rtl/alpha_coverage_statistics_core.sv]
// Top level of the alpha coverage statistics core.
// Depends on acs_pkg, acs_if, acs_front, acs_fifo and acs_back.
// Each pixel is handled in a histogram memory read state, then a write-back state;
// the engine pops the next pixel only after both; a two-entry queue lets the input
// accept pixels meanwhile. A pixel marked frame_end is followed by a histogram scan
// of all 256 alpha codes for the mode, a state to finish the last compare, a verdict
// state and then 30 record transactions, one per cycle when the sink is ready; input
// stalls once the queue fills.
// The sRGB decode enable register sits at byte address 0 of the APB port.
module alpha_coverage_statistics_core #(
  parameter int unsigned MaxPixels  = acs_pkg::MaxPixelsDef,
  parameter int unsigned NumBuckets = acs_pkg::NumBucketsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acs_pixel_if.sink    pix_i,
  acs_record_if.source rec_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import acs_pkg::*;

  logic  srgb_q;
  logic  push, full, pop, empty;
  item_t item, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2:1] == CFG_SRGB) ? {31'd0, srgb_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srgb_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2:1] == CFG_SRGB) begin
      srgb_q <= pwdata[0];
    end
  end

  acs_front u_front (
    .pix    (pix_i),
    .srgb_i (srgb_q),
    .full_i (full),
    .push_o (push),
    .item_o (item)
  );

  acs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  acs_back #(
    .MaxPixels  (MaxPixels),
    .NumBuckets (NumBuckets)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .rec     (rec_o)
  );

endmodule

[rtl/acs_front.sv]
// Front end: accepts pixels and classifies the premultiplication tests.
// Depends on acs_pkg and acs_pixel_if.
module acs_front (
  acs_pixel_if.sink     pix,
  input  logic          srgb_i,
  input  logic          full_i,
  output logic          push_o,
  output acs_pkg::item_t item_o
);
  import acs_pkg::*;

  logic [7:0]  max_c;
  logic [8:0]  lim;
  logic        raw_v;
  logic [15:0] lin;
  logic [23:0] lin255;
  logic [24:0] thr;

  always_comb begin
    max_c = pix.red;
    if (pix.green > max_c) max_c = pix.green;
    if (pix.blue > max_c) max_c = pix.blue;
    lim    = {1'b0, pix.alpha} + 9'd2;
    raw_v  = {1'b0, max_c} > lim;
    lin    = LinLut[max_c];
    lin255 = {lin, 8'b0} - {8'b0, lin};
    thr    = {lim, 16'b0};
  end

  assign pix.ready        = !full_i;
  assign push_o           = pix.valid && !full_i;
  assign item_o.alpha     = pix.alpha;
  assign item_o.frame_end = pix.frame_end;
  assign item_o.raw_viol  = raw_v;
  assign item_o.lin_viol  = srgb_i ? ({1'b0, lin255} > thr) : raw_v;

endmodule

[rtl/acs_fifo.sv]
// Two-entry queue between front end and statistics engine.
// Depends on acs_pkg.
module acs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acs_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output acs_pkg::item_t head_o,
  output logic           empty_o
);
  import acs_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[rtl/acs_back.sv]
// Statistics engine: histogram update, mode scan, verdicts and record readout.
// Depends on acs_pkg and acs_record_if.
module acs_back #(
  parameter int unsigned MaxPixels  = acs_pkg::MaxPixelsDef,
  parameter int unsigned NumBuckets = acs_pkg::NumBucketsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  acs_pkg::item_t head_i,
  output logic           pop_o,
  acs_record_if.source   rec
);
  import acs_pkg::*;

  localparam int unsigned CntW      = $clog2(MaxPixels + 1);
  localparam int unsigned BkW       = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int unsigned BucketDiv = 256 / NumBuckets;

  typedef logic [7:0] bk_lut_t [256];

  function automatic bk_lut_t build_bk_lut();
    bk_lut_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = (c / BucketDiv > NumBuckets - 1) ? 8'(NumBuckets - 1) : 8'(c / BucketDiv);
    end
    return t;
  endfunction

  localparam bk_lut_t BkLut = build_bk_lut();

  typedef enum logic [5:0] {
    ST_POP  = 6'b000001,
    ST_UPD  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_LAST = 6'b001000,
    ST_VERD = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e          state_q;
  item_t           item_q;
  logic [CntW-1:0] hist_mem [256];
  logic [255:0]    hist_vld_q;
  logic [CntW-1:0] rd_q;
  logic [7:0]      rd_addr;
  logic            mem_we;
  logic [CntW-1:0] cur;
  logic            cnt_en;
  logic [CntW-1:0] bucket_q [NumBuckets];
  logic [CntW-1:0] total_q, zero_q, mid_q, opaque_q, tested_q, linv_q, rawv_q;
  logic [7:0]      min_q, max_q;
  logic [31:0]     sum_q;
  logic [8:0]      scan_q;
  logic            cmp_vld_q;
  logic [7:0]      cmp_idx_q;
  logic [CntW-1:0] cmp_val;
  logic [7:0]      mode_code_q;
  logic [CntW-1:0] mode_cnt_q;
  logic [1:0]      pv_q, av_q;
  logic [4:0]      rec_cnt_q;
  logic            load;
  logic [7:0]      bk_raw;
  logic [BkW-1:0]  bk;
  logic [3:0]      bsel4;
  logic [BkW-1:0]  bsel;
  logic [31:0]     rec_val;
  logic            rec_vld_q;
  logic [4:0]      rec_idx_q;
  logic [31:0]     rec_val_q;

  assign pop_o   = (state_q == ST_POP) && !empty_i;
  assign rd_addr = (state_q == ST_POP) ? head_i.alpha : scan_q[7:0];
  assign cur     = hist_vld_q[item_q.alpha] ? rd_q : '0;
  assign cnt_en  = total_q < CntW'(MaxPixels);
  assign mem_we  = (state_q == ST_UPD) && cnt_en;
  assign cmp_val = hist_vld_q[cmp_idx_q] ? rd_q : '0;
  assign load    = (state_q == ST_OUT) && (!rec_vld_q || rec.ready);

  always_comb begin
    bk_raw = BkLut[item_q.alpha];
    bk     = BkW'(bk_raw);
    bsel4  = 4'(rec_cnt_q - REC_BUCKET0);
    bsel   = BkW'(bsel4);
  end

  always_comb begin
    case (rec_cnt_q)
      REC_TOTAL:     rec_val = 32'(total_q);
      REC_ZERO:      rec_val = 32'(zero_q);
      REC_MID:       rec_val = 32'(mid_q);
      REC_OPAQUE:    rec_val = 32'(opaque_q);
      REC_MIN:       rec_val = 32'(min_q);
      REC_MAX:       rec_val = 32'(max_q);
      REC_SUM:       rec_val = sum_q;
      REC_MODE_CODE: rec_val = 32'(mode_code_q);
      REC_MODE_CNT:  rec_val = 32'(mode_cnt_q);
      REC_TESTED:    rec_val = 32'(tested_q);
      REC_LIN_VIOL:  rec_val = 32'(linv_q);
      REC_RAW_VIOL:  rec_val = 32'(rawv_q);
      REC_PREMUL:    rec_val = 32'(pv_q);
      REC_ALPHA:     rec_val = 32'(av_q);
      default:       rec_val = (32'(bsel4) < NumBuckets) ? 32'(bucket_q[bsel]) : 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[item_q.alpha] <= cur + CntW'(1);
    rd_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= head_i;
    if (load) begin
      rec_idx_q <= rec_cnt_q;
      rec_val_q <= rec_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_POP;
      hist_vld_q  <= '0;
      for (int i = 0; i < NumBuckets; i++) bucket_q[i] <= '0;
      total_q     <= '0;
      zero_q      <= '0;
      mid_q       <= '0;
      opaque_q    <= '0;
      tested_q    <= '0;
      linv_q      <= '0;
      rawv_q      <= '0;
      min_q       <= 8'hff;
      max_q       <= '0;
      sum_q       <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      mode_code_q <= '0;
      mode_cnt_q  <= '0;
      pv_q        <= PREMUL_INCONCLUSIVE;
      av_q        <= ALPHA_MIXED;
      rec_cnt_q   <= '0;
      rec_vld_q   <= 1'b0;
    end else begin
      if (load) rec_vld_q <= 1'b1;
      else if (rec.ready) rec_vld_q <= 1'b0;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cmp_vld_q && (cmp_idx_q == 8'd0 || cmp_val > mode_cnt_q)) begin
        mode_code_q <= cmp_idx_q;
        mode_cnt_q  <= cmp_val;
      end
      unique case (state_q)
        ST_POP: begin
          if (!empty_i) state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (cnt_en) begin
            total_q <= total_q + CntW'(1);
            if (item_q.alpha < min_q) min_q <= item_q.alpha;
            if (item_q.alpha > max_q) max_q <= item_q.alpha;
            sum_q <= sum_q + 32'(item_q.alpha);
            hist_vld_q[item_q.alpha] <= 1'b1;
            bucket_q[bk] <= bucket_q[bk] + CntW'(1);
            if (item_q.alpha == 8'd0) begin
              zero_q <= zero_q + CntW'(1);
            end else if (item_q.alpha == 8'hff) begin
              opaque_q <= opaque_q + CntW'(1);
            end else begin
              mid_q    <= mid_q + CntW'(1);
              tested_q <= tested_q + CntW'(1);
              if (item_q.raw_viol) rawv_q <= rawv_q + CntW'(1);
              if (item_q.lin_viol) linv_q <= linv_q + CntW'(1);
            end
          end
          scan_q  <= '0;
          state_q <= item_q.frame_end ? ST_SCAN : ST_POP;
        end
        ST_SCAN: begin
          cmp_idx_q <= scan_q[7:0];
          scan_q    <= scan_q + 9'd1;
          if (scan_q[7:0] == 8'hff) state_q <= ST_LAST;
        end
        ST_LAST: begin
          state_q <= ST_VERD;
        end
        ST_VERD: begin
          if (tested_q == '0) pv_q <= PREMUL_INCONCLUSIVE;
          else if (linv_q != '0) pv_q <= PREMUL_NOT;
          else pv_q <= PREMUL_CONSISTENT;
          if (({10'd0, opaque_q} * 10'd1000) > ({10'd0, total_q} * 10'd999)) begin
            av_q <= ALPHA_OPAQUE;
          end else if (({4'd0, zero_q} * 4'd10) > ({4'd0, total_q} * 4'd9)) begin
            av_q <= ALPHA_ZERO;
          end else if (mode_code_q != 8'd0 && mode_code_q != 8'hff &&
                       ({4'd0, mode_cnt_q} * 4'd10) > ({4'd0, total_q} * 4'd9)) begin
            av_q <= ALPHA_UNIFORM;
          end else begin
            av_q <= ALPHA_MIXED;
          end
          rec_cnt_q <= '0;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (load) begin
            rec_cnt_q <= rec_cnt_q + 5'd1;
            if (rec_cnt_q == REC_LAST) begin
              hist_vld_q <= '0;
              for (int i = 0; i < NumBuckets; i++) bucket_q[i] <= '0;
              total_q  <= '0;
              zero_q   <= '0;
              mid_q    <= '0;
              opaque_q <= '0;
              tested_q <= '0;
              linv_q   <= '0;
              rawv_q   <= '0;
              min_q    <= 8'hff;
              max_q    <= '0;
              sum_q    <= '0;
              state_q  <= ST_POP;
            end
          end
        end
        default: state_q <= ST_POP;
      endcase
    end
  end

  assign rec.valid        = rec_vld_q;
  assign rec.record_index = rec_idx_q;
  assign rec.record_value = rec_val_q;
  assign rec.last_record  = rec_idx_q == REC_LAST;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rec_cnt_q == REC_LAST) |=> (hist_vld_q == '0 && total_q == '0))
    else $error("statistics not cleared after readout");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MaxPixels))
    else $error("pixel total beyond limit");
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (min_q <= max_q))
    else $error("alpha minimum above maximum");
  a_class_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> ((CntW+2)'(zero_q) + (CntW+2)'(mid_q) + (CntW+2)'(opaque_q)
                             == (CntW+2)'(total_q)))
    else $error("alpha class counts disagree with total");
`endif

endmodule
